[design/ebdq_pkg.sv]
// Types and constants shared by the error-bounded delta quantiser.
// No dependencies.
package ebdq_pkg;

  localparam int CODE_LIMIT = 32767;
  localparam logic [15:0] RAW_ESCAPE    = 16'h8000;
  localparam logic [15:0] ZIGZAG_ESCAPE = 16'hFFFF;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_BOUND   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZIGZAG_ENABLE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ERROR_BOUND_RESET = 31'd1;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               start_of_block;
  } ebdq_in_t;

  typedef struct packed {
    logic [15:0]        step_code;
    logic               is_outlier;
    logic signed [31:0] outlier_value;
  } ebdq_out_t;

endpackage

[design/error_bounded_delta_quantiser.sv]
// Error-bounded delta quantiser with radix-2 divider.
// Depends on ebdq_pkg.
// Each item goes through prep, the one-bit-per-cycle divider loop over NW quotient
//   bits and finish; NW = max(EW + 1, 31) + 1 and EW = min(SAMPLE_WIDTH, 32).
// A new item is taken only in idle, after finish has loaded the output register;
//   finish waits while that register holds a result that out_stall holds back.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): prediction 0, error_bound 1, zigzag off, channels empty.
module error_bounded_delta_quantiser
  import ebdq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ebdq_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ebdq_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int EW = (SAMPLE_WIDTH > 32) ? 32 : SAMPLE_WIDTH;
  localparam int NW = ((EW + 1 > 31) ? EW + 1 : 31) + 1;
  localparam int CW = $clog2(NW);
  localparam int RW = NW + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] eb_r;
  logic                  zz_r;
  logic signed [EW-1:0]  pred_r;
  logic signed [EW-1:0]  s_r;
  logic                  sob_r;
  logic                  neg_r;
  logic [NW-1:0]         num_r;
  logic [NW-1:0]         quo_r;
  logic [31:0]           rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  out_valid_r;
  ebdq_out_t             out_r;

  // error bound of zero acts as one; step is twice the bound
  logic [CFG_DATA_W-1:0] eb_eff;
  logic [31:0]           step;
  assign eb_eff = (eb_r == '0) ? CFG_DATA_W'(1) : eb_r;
  assign step   = {eb_eff, 1'b0};

  // prep: difference from prediction (or from zero at block start), magnitude plus half step
  logic signed [EW-1:0] base;
  logic [EW:0]          diff;
  logic [EW:0]          mag;
  logic [NW-1:0]        num;
  assign base = sob_r ? '0 : pred_r;
  assign diff = {s_r[EW-1], s_r} - {base[EW-1], base};
  assign mag  = diff[EW] ? ((EW+1)'(0) - diff) : diff;
  assign num  = NW'(mag) + NW'(eb_eff);

  // restoring divider step
  logic [32:0] trial;
  logic        q_bit;
  assign trial = {rem_r, quo_r[NW-1]};
  assign q_bit = (trial >= {1'b0, step});

  // finish: reconstruction and code; q*step = num - rem
  logic [NW-1:0]        qs;
  logic signed [RW-1:0] pred_x;
  logic signed [RW-1:0] qs_x;
  logic signed [RW-1:0] recon;
  logic                 fits;
  logic                 cnt_ok;
  logic                 ok;
  logic [14:0]          q15;
  logic [15:0]          mag16;
  logic [15:0]          raw_code;
  logic [15:0]          zz_code;
  logic                 out_free;

  assign qs     = num_r - NW'(rem_r);
  assign pred_x = RW'(pred_r);
  assign qs_x   = $signed({2'b00, qs});
  assign recon  = neg_r ? (pred_x - qs_x) : (pred_x + qs_x);
  assign fits   = (&recon[RW-1:EW-1]) | ~(|recon[RW-1:EW-1]);
  assign cnt_ok = ~(|quo_r[NW-1:15]);
  assign ok     = cnt_ok & fits;
  assign q15    = quo_r[14:0];
  assign mag16  = {1'b0, q15};
  assign raw_code = neg_r ? (16'd0 - mag16) : mag16;
  // negative counts map to odd codes
  assign zz_code  = (neg_r && (|q15)) ? ({q15, 1'b0} - 16'd1) : {q15, 1'b0};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eb_r        <= ERROR_BOUND_RESET;
      zz_r        <= 1'b0;
      pred_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ERROR_BOUND:   eb_r <= cfg_wdata;
          CFG_ZIGZAG_ENABLE: zz_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (state_r == ST_PREP) pred_r <= base;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        pred_r      <= ok ? recon[EW-1:0] : s_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      s_r   <= in_data.sample[EW-1:0];
      sob_r <= in_data.start_of_block;
    end
    if (state_r == ST_PREP) begin
      neg_r <= diff[EW];
      num_r <= num;
      quo_r <= num;
      rem_r <= '0;
      cnt_r <= CW'(NW - 1);
    end
    if (state_r == ST_DIV) begin
      rem_r <= q_bit ? 32'(trial - {1'b0, step}) : trial[31:0];
      quo_r <= {quo_r[NW-2:0], q_bit};
      cnt_r <= cnt_r - 1'b1;
    end
    if (state_r == ST_FIN && out_free) begin
      if (ok) begin
        out_r.step_code     <= zz_r ? zz_code : raw_code;
        out_r.is_outlier    <= 1'b0;
        out_r.outlier_value <= '0;
      end else begin
        out_r.step_code     <= zz_r ? ZIGZAG_ESCAPE : RAW_ESCAPE;
        out_r.is_outlier    <= 1'b1;
        out_r.outlier_value <= 32'(s_r);
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_PREP))
    else $error("accepted item did not start processing");

  a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < step))
    else $error("divider remainder not below step");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not loaded into output register");

  a_escape_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_outlier) |->
      (out_r.step_code == RAW_ESCAPE || out_r.step_code == ZIGZAG_ESCAPE))
    else $error("outlier without escape code");

  a_inlier_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.is_outlier) |-> (out_r.outlier_value == '0))
    else $error("inlier carries a nonzero outlier value");
`endif

endmodule

[verif/error_bounded_delta_quantiser_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for error_bounded_delta_quantiser: directed edge samples, then
// random phases under varied bound/zigzag settings with random stalls. Needs ebdq_pkg.
module error_bounded_delta_quantiser_test;
  import ebdq_pkg::*;

  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 191;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  ebdq_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  ebdq_out_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ERROR_BOUND;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // predictor state, mirrors the block's registers
  logic [CFG_DATA_W-1:0] bound_reg = ERROR_BOUND_RESET;
  bit                    zigzag_reg = 1'b0;
  longint                recon_prev = 0;

  ebdq_in_t  sample_q[$];
  ebdq_out_t quant_results_q[$];

  int  tx_wait = 0;
  int  rx_wait = 0;
  int  hold_request = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  quiet = 0;
  int  mismatches = 0;

  error_bounded_delta_quantiser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic ebdq_out_t quantise(ebdq_in_t it);
    ebdq_out_t r;
    longint s, eb, stp, diff, mag, q, recon, err, code;
    bit fits;
    s = longint'($signed(it.sample));
    eb = (bound_reg == 0) ? 1 : longint'(bound_reg);
    stp = 2 * eb;
    if (it.start_of_block) recon_prev = 0;
    diff = s - recon_prev;
    mag = (diff < 0) ? -diff : diff;
    mag = (mag + eb) / stp;  // round half away from zero
    fits = (mag <= CODE_LIMIT);
    q = fits ? mag : 0;
    if (diff < 0) q = -q;
    recon = recon_prev + q * stp;
    err = s - recon;
    if (err < 0) err = -err;
    if (recon > S_MAX || recon < S_MIN || err > eb) fits = 1'b0;
    if (fits) begin
      if (zigzag_reg) code = (q < 0) ? (-2 * q - 1) : (2 * q);
      else code = q;
      r.step_code = code[15:0];
      r.is_outlier = 1'b0;
      r.outlier_value = '0;
      recon_prev = recon;
    end else begin
      r.step_code = zigzag_reg ? ZIGZAG_ESCAPE : RAW_ESCAPE;
      r.is_outlier = 1'b1;
      r.outlier_value = it.sample;
      recon_prev = s;
    end
    return r;
  endfunction

  // mostly zero, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [31:0] next_sample(longint last, longint eb);
    longint k, v;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) k = longint'($urandom_range(0, 80)) - 40;
    else k = ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(32765, 32768));
    if (pick < 70) v = last + k * 2 * eb + longint'($urandom_range(0, 32'(2 * eb))) - eb;
    else if (pick < 88) v = longint'($signed($urandom()));
    else begin
      case ($urandom_range(0, 4))
        0: v = S_MAX;
        1: v = S_MIN;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end
    return v[31:0];
  endfunction

  task automatic push_sample(input logic [31:0] s, input bit sob);
    ebdq_in_t it;
    it.sample = s;
    it.start_of_block = sob;
    sample_q = {sample_q, it};
  endtask

  task automatic load_random(input int count, input logic [CFG_DATA_W-1:0] bound);
    ebdq_in_t it;
    longint eb, last;
    eb = (bound == 0) ? 1 : longint'(bound);
    last = 0;
    repeat (count) begin
      it.start_of_block = ($urandom_range(0, 15) == 0);
      if (it.start_of_block) last = 0;
      it.sample = next_sample(last, eb);
      last = longint'($signed(it.sample));
      sample_q = {sample_q, it};
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ERROR_BOUND) bound_reg = val;
    else zigzag_reg = val[0];
  endtask

  // wait until every queued item has gone in and every result has come back
  task automatic drain();
    do @(negedge clk); while (sample_q.size() > 0 || in_valid || quant_results_q.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result(input ebdq_out_t got);
    ebdq_out_t want;
    if (quant_results_q.size() == 0) begin
      $error("result with nothing pending: step_code %h", got.step_code);
      mismatches++;
    end else begin
      want = quant_results_q.pop_front();
      if (got.step_code !== want.step_code) begin
        $error("step_code: expected %h, got %h", want.step_code, got.step_code);
        mismatches++;
      end
      if (got.is_outlier !== want.is_outlier) begin
        $error("is_outlier: expected %b, got %b", want.is_outlier, got.is_outlier);
        mismatches++;
      end
      if (got.outlier_value !== want.outlier_value) begin
        $error("outlier_value: expected %h, got %h", want.outlier_value, got.outlier_value);
        mismatches++;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) quant_results_q = {quant_results_q, quantise(in_data)};
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
          tx_wait = tx_steady ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_request > 0) begin
        rx_wait = hold_request;
        hold_request = 0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_wait = rx_steady ? 0 : idle_len();
      end
    end
  end

  // no progress on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= IDLE_LIMIT) begin
          $display("error_bounded_delta_quantiser_test: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_bound;
    bit phase_zz;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: bound 1, raw codes; ties, code limits, extremes
    push_sample(32'd0, 1'b1);
    push_sample(32'd2, 1'b0);
    push_sample(32'd3, 1'b0);
    push_sample(32'd3, 1'b0);
    push_sample(32'd65536, 1'b1);       // count just past the limit
    push_sample(32'd131070, 1'b0);      // +32767
    push_sample(32'd65536, 1'b0);       // -32767
    push_sample(32'd1, 1'b0);           // -32768 rounds out of range
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h8000_0001, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'hAAAA_AAAA, 1'b0);
    drain();

    // huge step, zigzag on; upper data bits junk on the enable write
    write_reg(CFG_ERROR_BOUND, 31'h4000_0000);
    write_reg(CFG_ZIGZAG_ENABLE, 31'h2AAA_AAAB);
    @(negedge clk);
    push_sample(32'h7FFF_FFFF, 1'b1);   // reconstruction overflows
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'd0, 1'b0);           // positive step back to zero
    push_sample(32'h4000_0000, 1'b1);   // tie rounds up, overflows
    push_sample(32'hC000_0000, 1'b1);
    push_sample(32'h3FFF_FFFF, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: phase_bound = '0;             // zero bound acts as one
        1: phase_bound = 31'd1;
        2: phase_bound = 31'd5;
        3: phase_bound = 31'd1000;
        4: phase_bound = 31'h7FFF_FFFF;
        5: phase_bound = 31'd65536;
        6: phase_bound = 31'($urandom_range(1, 32'h7FFF_FFFF));
        default: phase_bound = 31'($urandom_range(1, 300));
      endcase
      phase_zz = (p % 2 == 0);
      write_reg(CFG_ERROR_BOUND, phase_bound);
      write_reg(CFG_ZIGZAG_ENABLE, {30'($urandom()), phase_zz});
      @(negedge clk);
      tx_steady = (p == 2) || (p == 5);
      rx_steady = (p == 5);
      // long receiver hold while the sender keeps pushing
      if (p == 2) hold_request = 400;
      load_random(ITEMS_PER_PHASE, phase_bound);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("error_bounded_delta_quantiser_test: PASS");
    end else begin
      $display("error_bounded_delta_quantiser_test: FAIL");
    end
    $finish;
  end

endmodule
